/* rtl/usqks_pkg.sv */
// ----------------------------------------------------------------------------
// usqks_pkg
// Shared types, keyword table and key matching functions for the URL
// sensitive query key scanner.
// ----------------------------------------------------------------------------
package usqks_pkg;

   localparam int NUM_KEYWORDS        = 20;
   localparam int KEY_MAX             = 20;
   localparam int SCHEME_MAX          = 5;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef logic [NUM_KEYWORDS-1:0] kw_mask_type;
   typedef logic [4:0]              key_len_type;
   typedef logic [4:0]              kw_index_type;

   typedef enum logic [1:0] {
      VERDICT_PENDING,
      VERDICT_PASS,
      VERDICT_FAIL
   } verdict_type;

   typedef enum logic [2:0] {
      TOK_SKIP,
      TOK_AMP,
      TOK_EQ,
      TOK_PCT,
      TOK_TEXT
   } token_kind_type;

   typedef enum logic [1:0] {
      PCT_NONE,
      PCT_ONE,
      PCT_TWO
   } pct_state_type;

   // one classified url byte as it travels from front to back
   typedef struct packed {
      logic [7:0]     data;
      token_kind_type kind;
      logic           is_hex;
      logic [3:0]     nibble;
      logic           last;
      logic           scheme_pass;
   } token_type;

   typedef struct packed {
      kw_mask_type live;
      key_len_type length;
      logic        closed;
   } key_state_type;

   localparam logic [7:0] KW_LEN [NUM_KEYWORDS] = '{
      8'd12, 8'd7, 8'd6, 8'd10, 8'd13, 8'd14, 8'd13, 8'd10, 8'd11, 8'd3,
      8'd8, 8'd6, 8'd6, 8'd10, 8'd9, 8'd5, 8'd20, 8'd15, 8'd20, 8'd15
   };

   // right-aligned text, first character in the highest used byte
   localparam logic [KEY_MAX*8-1:0] KW_TEXT [NUM_KEYWORDS] = '{
      {"access", "_token"}, "api_key", "apikey", {"auth", "_token"}, "authorization",
      "awsaccesskeyid", {"client", "_secret"}, "credential", "credentials", "jwt",
      "password", "passwd", "secret", {"session", "_id"}, "signature", "token",
      {"x_amz", "_security_token"}, {"x_amz", "_signature"}, "x-amz-security-token",
      "x-amz-signature"
   };

   function automatic logic [7:0] kw_char(int unsigned idx, key_len_type pos);
      logic [KEY_MAX*8-1:0] aligned;
      logic [7:0]           ch;
      aligned = KW_TEXT[idx] << (8 * (KEY_MAX - int'(KW_LEN[idx])));
      ch = 8'h00;
      if (int'(pos) < KEY_MAX) begin
         ch = aligned[8*(KEY_MAX-1-int'(pos)) +: 8];
      end
      return ch;
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
             (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_val(logic [7:0] c);
      logic [7:0] v;
      if (c >= "0" && c <= "9") begin
         v = c - "0";
      end else if (c >= "a" && c <= "f") begin
         v = c - "a" + 8'd10;
      end else begin
         v = c - "A" + 8'd10;
      end
      return v[3:0];
   endfunction

   function automatic logic [7:0] scheme_char(logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = "h";
         3'd1:    ch = "t";
         3'd2:    ch = "t";
         3'd3:    ch = "p";
         default: ch = "s";
      endcase
      return ch;
   endfunction

   // one decoded key character against all live keywords
   function automatic key_state_type key_push(key_state_type s, logic [7:0] c);
      key_state_type r;
      logic [7:0]    ch;
      r  = s;
      ch = c;
      if (!s.closed) begin
         if (c == 8'h00) begin
            r.closed = 1'b1;
         end else begin
            if (c >= "A" && c <= "Z") begin
               ch = c + 8'd32;
            end
            if (int'(s.length) >= KEY_MAX) begin
               r.live = '0;
            end else begin
               for (int i = 0; i < NUM_KEYWORDS; i++) begin
                  if (KW_LEN[i] <= {3'b000, s.length} || kw_char(i, s.length) != ch) begin
                     r.live[i] = 1'b0;
                  end
               end
               r.length = s.length + 5'd1;
            end
         end
      end
      return r;
   endfunction

   function automatic kw_mask_type len_filter(key_len_type len);
      kw_mask_type m;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         m[i] = (KW_LEN[i] == {3'b000, len});
      end
      return m;
   endfunction

   function automatic kw_index_type first_set(kw_mask_type m);
      kw_index_type idx;
      idx = '0;
      for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = 5'(i);
         end
      end
      return idx;
   endfunction

endpackage

/* rtl/usqks_front.sv */
// ----------------------------------------------------------------------------
// usqks_front
// Accepts url bytes, checks the scheme prefix, tracks the query start and
// tags every byte with its token class for the back end.
// ----------------------------------------------------------------------------
module usqks_front import usqks_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_tvalid,
   output logic      req_tready,
   input  logic [7:0] req_tdata,    // url_byte
   input  logic      req_tlast,     // last_byte
   input  logic      queue_full,
   output logic      tok_push,
   output token_type tok
);

   logic [2:0]  scheme_pos_ff, scheme_pos_in;
   verdict_type verdict_ff, verdict_in;
   logic        prefix_ff, prefix_in;
   logic        in_query_ff, in_query_in;

   assign req_tready = !queue_full;
   assign tok_push   = req_tvalid && !queue_full;

   always_comb begin
      scheme_pos_in = scheme_pos_ff;
      verdict_in    = verdict_ff;
      prefix_in     = prefix_ff;
      in_query_in   = in_query_ff;

      if (verdict_ff == VERDICT_PENDING) begin
         if (req_tdata == ":") begin
            verdict_in = ((scheme_pos_ff == 3'd4 || scheme_pos_ff == 3'd5) && prefix_ff)
                         ? VERDICT_PASS : VERDICT_FAIL;
         end else if (int'(scheme_pos_ff) >= SCHEME_MAX) begin
            verdict_in = VERDICT_FAIL;
         end else begin
            if (req_tdata != scheme_char(scheme_pos_ff)) begin
               prefix_in = 1'b0;
            end
            scheme_pos_in = scheme_pos_ff + 3'd1;
         end
      end

      if (req_tdata == "?") begin
         in_query_in = 1'b1;
      end

      tok.data        = req_tdata;
      tok.is_hex      = is_hex(req_tdata);
      tok.nibble      = hex_val(req_tdata);
      tok.last        = req_tlast;
      tok.scheme_pass = (verdict_in == VERDICT_PASS);
      if (!in_query_ff) begin
         tok.kind = TOK_SKIP;
      end else if (req_tdata == "&") begin
         tok.kind = TOK_AMP;
      end else if (req_tdata == "=") begin
         tok.kind = TOK_EQ;
      end else if (req_tdata == "%") begin
         tok.kind = TOK_PCT;
      end else begin
         tok.kind = TOK_TEXT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_pos_ff <= '0;
         verdict_ff    <= VERDICT_PENDING;
         prefix_ff     <= 1'b1;
         in_query_ff   <= 1'b0;
      end else if (tok_push) begin
         if (req_tlast) begin
            scheme_pos_ff <= '0;
            verdict_ff    <= VERDICT_PENDING;
            prefix_ff     <= 1'b1;
            in_query_ff   <= 1'b0;
         end else begin
            scheme_pos_ff <= scheme_pos_in;
            verdict_ff    <= verdict_in;
            prefix_ff     <= prefix_in;
            in_query_ff   <= in_query_in;
         end
      end
   end

endmodule

/* rtl/usqks_queue.sv */
// ----------------------------------------------------------------------------
// usqks_queue
// Short token queue between the classifying front and the matching back.
// ----------------------------------------------------------------------------
module usqks_queue import usqks_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_tok,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output token_type head_tok
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   token_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_tok   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("token queue count above depth");
`endif

endmodule

/* rtl/usqks_back.sv */
// ----------------------------------------------------------------------------
// usqks_back
// Splits query pairs, percent-decodes keys, narrows the keyword mask and
// holds the per-url verdict in the result register.
// ----------------------------------------------------------------------------
module usqks_back import usqks_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       tok_valid,
   input  token_type  tok,
   output logic       tok_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata     // found, keyword_index[4:0], zero pad
);

   key_state_type key_ff, key_in;
   pct_state_type pct_ff, pct_in;
   logic [7:0]    high_ff, high_in;
   logic [3:0]    high_nib_ff, high_nib_in;
   logic          in_value_ff, in_value_in;
   logic          hit_ff, hit_in;
   kw_index_type  hit_index_ff, hit_index_in;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_data_ff;
   logic          found;

   localparam key_state_type KEY_FRESH = '{live: '1, length: '0, closed: 1'b0};

   assign tok_pop    = tok_valid && (!tok.last || !rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      key_in       = key_ff;
      pct_in       = pct_ff;
      high_in      = high_ff;
      high_nib_in  = high_nib_ff;
      in_value_in  = in_value_ff;
      hit_in       = hit_ff;
      hit_index_in = hit_index_ff;

      if (tok.kind != TOK_SKIP) begin
         if (tok.kind == TOK_AMP) begin
            key_in      = KEY_FRESH;
            pct_in      = PCT_NONE;
            high_in     = '0;
            in_value_in = 1'b0;
         end else if (in_value_ff) begin
            // first value byte decides the hit for this pair
            if (key_ff.live != '0 && !hit_ff) begin
               hit_in       = 1'b1;
               hit_index_in = first_set(key_ff.live);
            end
            key_in.live = '0;
         end else if (tok.kind == TOK_EQ) begin
            if (pct_ff != PCT_NONE) begin
               key_in = key_push(key_in, "%");
            end
            if (pct_ff == PCT_TWO) begin
               key_in = key_push(key_in, high_ff);
            end
            pct_in      = PCT_NONE;
            key_in.live = key_in.live & len_filter(key_in.length);
            in_value_in = 1'b1;
         end else begin
            case (pct_ff)
               PCT_NONE: begin
                  if (tok.kind == TOK_PCT) begin
                     pct_in = PCT_ONE;
                  end else begin
                     key_in = key_push(key_in, tok.data);
                  end
               end
               PCT_ONE: begin
                  if (tok.is_hex) begin
                     high_in     = tok.data;
                     high_nib_in = tok.nibble;
                     pct_in      = PCT_TWO;
                  end else begin
                     key_in = key_push(key_in, "%");
                     pct_in = PCT_NONE;
                     if (tok.kind == TOK_PCT) begin
                        pct_in = PCT_ONE;
                     end else begin
                        key_in = key_push(key_in, tok.data);
                     end
                  end
               end
               default: begin
                  if (tok.is_hex) begin
                     key_in = key_push(key_in, {high_nib_ff, tok.nibble});
                     pct_in = PCT_NONE;
                  end else begin
                     // broken escape: both held characters go through literally
                     key_in = key_push(key_in, "%");
                     key_in = key_push(key_in, high_ff);
                     pct_in = PCT_NONE;
                     if (tok.kind == TOK_PCT) begin
                        pct_in = PCT_ONE;
                     end else begin
                        key_in = key_push(key_in, tok.data);
                     end
                  end
               end
            endcase
         end
      end

      found = tok.scheme_pass && hit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= KEY_FRESH;
         pct_ff       <= PCT_NONE;
         high_ff      <= '0;
         high_nib_ff  <= '0;
         in_value_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         hit_index_ff <= '0;
      end else if (tok_pop) begin
         if (tok.last) begin
            key_ff       <= KEY_FRESH;
            pct_ff       <= PCT_NONE;
            high_ff      <= '0;
            high_nib_ff  <= '0;
            in_value_ff  <= 1'b0;
            hit_ff       <= 1'b0;
            hit_index_ff <= '0;
         end else begin
            key_ff       <= key_in;
            pct_ff       <= pct_in;
            high_ff      <= high_in;
            high_nib_ff  <= high_nib_in;
            in_value_ff  <= in_value_in;
            hit_ff       <= hit_in;
            hit_index_ff <= hit_index_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tok_pop && tok.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_pop && tok.last) begin
         rsp_data_ff <= {2'b00, (found ? hit_index_in : 5'd0), found};
      end
   end

`ifndef SYNTHESIS
   a_index_zero_when_miss : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[0] |-> rsp_data_ff[5:1] == 5'd0)
      else $error("keyword index set without a hit");

   a_index_in_table : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> int'(rsp_data_ff[5:1]) < NUM_KEYWORDS)
      else $error("keyword index beyond table");

   a_last_makes_result : assert property (@(posedge clock) disable iff (reset)
      tok_pop && tok.last |=> rsp_valid_ff)
      else $error("last byte consumed without result");
`endif

endmodule

/* rtl/url_sensitive_query_key_scanner.sv */
// ----------------------------------------------------------------------------
// url_sensitive_query_key_scanner
// Flags a URL whose query carries a sensitive key with a non-empty value.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one url byte per transaction in req_tdata, req_tlast on the
//   final byte. One result per url comes out on rsp_* after the last byte:
//   rsp_tdata[0] is found, rsp_tdata[5:1] the keyword index (0 on a miss).
//   The scheme must be http or https, keys are percent-decoded, lower-cased
//   and compared against twenty keywords; the first matching key with a
//   value wins.
//   Throughput is one byte per cycle unless the queue is full. The front
//   tags each byte and writes it to a QUEUE_DEPTH entry token queue; the
//   back takes one token a cycle, save for the stall below, and registers
//   the verdict in the result register once the last byte leaves the queue.
//   While a result waits on rsp_tready the back stalls only on the next
//   url's last byte; the queue keeps absorbing bytes and req_tready falls
//   when it fills.
//   Synchronous reset empties the queue, drops any pending result and
//   starts a fresh url; the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module url_sensitive_query_key_scanner import usqks_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // url_byte[7:0]
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata     // found, keyword_index[4:0], zero pad[7:6]
);

   logic      queue_full;
   logic      tok_push;
   token_type front_tok;
   logic      tok_pop;
   logic      head_valid;
   token_type head_tok;

   usqks_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .tok_push   (tok_push),
      .tok        (front_tok)
   );

   usqks_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (tok_push),
      .push_tok   (front_tok),
      .full       (queue_full),
      .pop        (tok_pop),
      .head_valid (head_valid),
      .head_tok   (head_tok)
   );

   usqks_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (head_valid),
      .tok        (head_tok),
      .tok_pop    (tok_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
